>>> hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// Tag stack package
// Shared types, codes and the group membership test for the tag stack.
// ----------------------------------------------------------------------------
package tss_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH        = 3'd0,
    REQ_POP         = 3'd1,
    REQ_TEST        = 3'd2,
    REQ_COUNT_ALL   = 3'd3,
    REQ_COUNT_BELOW = 3'd4,
    REQ_REMOVE      = 3'd5,
    REQ_PEEK        = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLOSE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     below_gap;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EXEC = 3'd1,
    S_CMP  = 3'd2,
    S_SCAN = 3'd3,
    S_FIN  = 3'd4
  } state_t;

  localparam int CFG_W = 16;

  localparam logic [1:0] CFG_GROUP_A = 2'd0;
  localparam logic [1:0] CFG_GROUP_B = 2'd1;
  localparam logic [1:0] CFG_GROUP_C = 2'd2;
  localparam logic [1:0] CFG_GROUP_D = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] a;
    logic [CFG_W-1:0] b;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] d;
  } group_set_t;

  function automatic logic in_group(logic [31:0] tag, group_set_t g);
    in_group = (tag != 32'd0) &&
               (tag == 32'(g.a) || tag == 32'(g.b) ||
                tag == 32'(g.c) || tag == 32'(g.d));
  endfunction

endpackage

>>> hdl/tss_cell.sv
// ----------------------------------------------------------------------------
// Tag stack cell
// One stack entry. It shifts toward or away from the top with its neighbors
// and registers its own key match and group membership every cycle.
// ----------------------------------------------------------------------------
module tss_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  tss_pkg::cell_cmd_t    cmd,
  input  logic [TAG_BITS-1:0]   up_tag,
  input  logic [TAG_BITS-1:0]   dn_tag,
  input  logic [TAG_BITS-1:0]   key,
  input  tss_pkg::group_set_t   gset,
  output logic [TAG_BITS-1:0]   entry,
  output logic                  match,
  output logic                  member
);
  import tss_pkg::*;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PUSH: entry <= up_tag;
      OP_POP, OP_CLOSE: begin
        if (cmd.below_gap) begin
          entry <= dn_tag;
        end
      end
      default: entry <= entry;
    endcase
    match  <= (entry == key);
    member <= in_group(32'(entry), gset);
  end

endmodule

>>> hdl/tag_stack_with_search.sv
// ----------------------------------------------------------------------------
// Tag stack with search
// Open-tag stack built as a row of entry cells with a scan sequencer.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// The four group tag registers are written through cfg_we, cfg_index and
// cfg_data, one register per write. The user must write them only while no
// transaction is in flight; the block does not enforce it. Every request
// yields one result, shown for one cycle with done high; the receiver
// cannot stall, and busy goes low in the same cycle that done is shown, so
// the next request may be taken then. Push, pop, peek and the unused
// request code go through S_EXEC. Test, count and remove first latch a
// parallel compare in every cell, then a scan walks the registered match
// bits one entry per cycle from the top until it passes the last occupied
// entry; test and remove stop at the topmost match. The entry cells shift
// in parallel for push, pop and the gap closing of remove. Synchronous
// reset empties the stack and clears the group registers; the stored tags
// are not cleared and only occupied entries are ever read.
// ----------------------------------------------------------------------------
module tag_stack_with_search #(
  parameter int DEPTH    = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   req_type,
  input  logic [TAG_BITS-1:0]          tag_code,
  input  logic [5:0]                   level,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  output logic                         done,
  output logic [TAG_BITS-1:0]          tag_out,
  output logic                         found,
  output logic [$clog2(DEPTH+1)-1:0]   group_count,
  output logic [1:0]                   status,
  output logic [$clog2(DEPTH+1)-1:0]   depth_out
);
  import tss_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  state_t              state, state_next;
  req_t                req;
  logic [TAG_BITS-1:0] key;
  logic [5:0]          lev;
  group_set_t          gset;

  logic [CNT_W-1:0]    fill, fill_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic                seen, seen_next;

  cell_op_t            op;
  cell_cmd_t           cell_cmd [DEPTH];
  logic [TAG_BITS-1:0] cell_tag [DEPTH];
  logic [DEPTH-1:0]    match_bits;
  logic [DEPTH-1:0]    grp_bits;

  logic                accept;
  logic                is_search;
  logic                occ, m, g, scan_end;
  logic [IDX_W-1:0]    peek_idx;

  logic                res_load;
  logic [TAG_BITS-1:0] res_tag;
  logic                res_found;
  logic [CNT_W-1:0]    res_cnt;
  status_t             res_status;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign is_search = (req_type == REQ_TEST) || (req_type == REQ_COUNT_ALL) ||
                     (req_type == REQ_COUNT_BELOW) || (req_type == REQ_REMOVE);

  assign occ      = (idx < fill);
  assign m        = match_bits[idx[IDX_W-1:0]] && occ;
  assign g        = grp_bits[idx[IDX_W-1:0]] && occ;
  assign scan_end = !occ || (m && (req == REQ_TEST || req == REQ_REMOVE));
  assign peek_idx = IDX_W'(lev);

  genvar j;
  generate
    for (j = 0; j < DEPTH; j++) begin : g_cell
      logic [TAG_BITS-1:0] up_tag;
      logic [TAG_BITS-1:0] dn_tag;

      if (j == 0) begin : g_top
        assign up_tag = key;
      end else begin : g_mid
        assign up_tag = cell_tag[j-1];
      end
      if (j == DEPTH - 1) begin : g_bottom
        assign dn_tag = cell_tag[j];
      end else begin : g_inner
        assign dn_tag = cell_tag[j+1];
      end

      assign cell_cmd[j].op        = op;
      assign cell_cmd[j].below_gap = (op == OP_POP) || (32'(j) >= 32'(pos));

      tss_cell #(
        .TAG_BITS(TAG_BITS)
      ) u_cell (
        .clk    (clk),
        .cmd    (cell_cmd[j]),
        .up_tag (up_tag),
        .dn_tag (dn_tag),
        .key    (key),
        .gset   (gset),
        .entry  (cell_tag[j]),
        .match  (match_bits[j]),
        .member (grp_bits[j])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_search ? S_CMP : S_EXEC;
        end
      end
      S_EXEC: state_next = S_IDLE;
      S_CMP:  state_next = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_FIN;
        end
      end
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op         = OP_HOLD;
    fill_next  = fill;
    idx_next   = idx;
    cnt_next   = cnt;
    seen_next  = seen;
    pos_next   = pos;
    res_load   = 1'b0;
    res_tag    = '0;
    res_found  = 1'b0;
    res_cnt    = '0;
    res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next  = '0;
          cnt_next  = '0;
          seen_next = 1'b0;
          pos_next  = '0;
        end
      end
      S_EXEC: begin
        res_load = 1'b1;
        unique case (req)
          REQ_PUSH: begin
            if (fill == CNT_W'(DEPTH)) begin
              res_status = ST_OVERFLOW;
            end else begin
              op        = OP_PUSH;
              fill_next = fill + 1'b1;
            end
          end
          REQ_POP: begin
            if (fill == '0) begin
              res_status = ST_UNDERFLOW;
            end else if (fill == CNT_W'(1)) begin
              res_tag    = cell_tag[0];
              res_status = ST_UNDERFLOW;
            end else begin
              op        = OP_POP;
              res_tag   = cell_tag[0];
              fill_next = fill - 1'b1;
            end
          end
          REQ_PEEK: begin
            if (32'(lev) < 32'(fill)) begin
              res_tag = cell_tag[peek_idx];
            end
          end
          default: res_status = ST_OK;
        endcase
      end
      S_SCAN: begin
        idx_next = idx + 1'b1;
        if (m && !seen) begin
          seen_next = 1'b1;
          pos_next  = idx[IDX_W-1:0];
        end
        if (g && (req == REQ_COUNT_ALL || (req == REQ_COUNT_BELOW && seen))) begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: begin
        res_load = 1'b1;
        unique case (req)
          REQ_TEST: res_found = seen;
          REQ_COUNT_ALL: res_cnt = cnt;
          REQ_COUNT_BELOW: begin
            res_found = seen;
            res_cnt   = seen ? cnt : '0;
          end
          REQ_REMOVE: begin
            if (seen) begin
              res_found = 1'b1;
              op        = OP_CLOSE;
              fill_next = fill - 1'b1;
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
          default: res_status = ST_OK;
        endcase
      end
      default: op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
      gset  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= res_load;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GROUP_A: gset.a <= cfg_data;
          CFG_GROUP_B: gset.b <= cfg_data;
          CFG_GROUP_C: gset.c <= cfg_data;
          CFG_GROUP_D: gset.d <= cfg_data;
          default:     gset   <= gset;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_t'(req_type);
      key <= tag_code;
      lev <= level;
    end
    idx  <= idx_next;
    cnt  <= cnt_next;
    seen <= seen_next;
    pos  <= pos_next;
    if (res_load) begin
      tag_out     <= res_tag;
      found       <= res_found;
      group_count <= res_cnt;
      status      <= res_status;
      depth_out   <= fill_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_EXEC || $past(state) == S_FIN))
    else $error("result strobe without a finishing cycle");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count beyond stack depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_depth_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (depth_out == fill))
    else $error("reported depth differs from fill count");
`endif

endmodule

>>> tb/sv/tag_stack_with_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag stack with search testbench
// Drives push, pop, search, group count, remove and peek requests into the
// tag stack. Group tag registers are rewritten between phases. A behavioral
// stack inside the testbench predicts every result, and each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tag_stack_with_search_tb;
  import tss_pkg::*;

  localparam int DEPTH         = 64;
  localparam int TAG_BITS      = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 80;

  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic [TAG_BITS-1:0] tag;
    logic                found;
    logic [CNT_W-1:0]    count;
    logic [1:0]          status;
    logic [CNT_W-1:0]    depth;
  } stack_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic [2:0]          req_type  = REQ_PUSH;
  logic [TAG_BITS-1:0] tag_code  = '0;
  logic [5:0]          level     = '0;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = CFG_GROUP_A;
  logic [15:0]         cfg_data  = '0;
  logic                busy;
  logic                done;
  logic [TAG_BITS-1:0] tag_out;
  logic                found;
  logic [CNT_W-1:0]    group_count;
  logic [1:0]          status;
  logic [CNT_W-1:0]    depth_out;

  logic [TAG_BITS-1:0] model_stack [DEPTH];
  int                  model_fill = 0;
  logic [15:0]         group_tags [4] = '{16'h0, 16'h0, 16'h0, 16'h0};
  stack_result_t       pending_results [$];
  int                  fail_count = 0;
  int                  cycle_count = 0;
  int                  overflow_hits = 0;
  bit                  idle_enable = 1'b1;

  tag_stack_with_search #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .tag_code    (tag_code),
    .level       (level),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .tag_out     (tag_out),
    .found       (found),
    .group_count (group_count),
    .status      (status),
    .depth_out   (depth_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int top_match(input logic [TAG_BITS-1:0] tag);
    for (int i = model_fill - 1; i >= 0; i--) begin
      if (model_stack[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic int count_members(input int limit);
    int n;
    n = 0;
    for (int i = 0; i < limit; i++) begin
      if (model_stack[i] != '0 &&
          (model_stack[i] == group_tags[0] || model_stack[i] == group_tags[1] ||
           model_stack[i] == group_tags[2] || model_stack[i] == group_tags[3]))
        n++;
    end
    return n;
  endfunction

  function automatic stack_result_t apply_request(input logic [2:0] req,
                                                  input logic [TAG_BITS-1:0] tag,
                                                  input logic [5:0] lev);
    stack_result_t r;
    int pos;
    r = '{tag: '0, found: 1'b0, count: '0, status: ST_OK, depth: '0};
    case (req)
      REQ_PUSH: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
          overflow_hits++;
        end else begin
          model_stack[model_fill] = tag;
          model_fill++;
        end
      end
      REQ_POP: begin
        if (model_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (model_fill == 1) begin
          r.tag = model_stack[0];
          r.status = ST_UNDERFLOW;
        end else begin
          model_fill--;
          r.tag = model_stack[model_fill];
        end
      end
      REQ_TEST: r.found = (top_match(tag) >= 0);
      REQ_COUNT_ALL: r.count = CNT_W'(count_members(model_fill));
      REQ_COUNT_BELOW: begin
        pos = top_match(tag);
        if (pos >= 0) begin
          r.found = 1'b1;
          r.count = CNT_W'(count_members(pos));
        end
      end
      REQ_REMOVE: begin
        pos = top_match(tag);
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          for (int i = pos; i + 1 < model_fill; i++) model_stack[i] = model_stack[i + 1];
          model_fill--;
        end
      end
      REQ_PEEK: begin
        if (int'(lev) < model_fill) r.tag = model_stack[model_fill - 1 - int'(lev)];
      end
      default: begin
      end
    endcase
    r.depth = CNT_W'(model_fill);
    return r;
  endfunction

  task automatic send_item(input logic [2:0] req, input logic [TAG_BITS-1:0] tag,
                           input logic [5:0] lev);
    int gap;
    if (idle_enable && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    req_type = req;
    tag_code = tag;
    level = lev;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(req, tag, lev));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_group(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    group_tags[idx] = value;
  endtask

  task automatic set_group_tags(input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] c, input logic [15:0] d);
    wait_drained();
    write_group(CFG_GROUP_A, a);
    write_group(CFG_GROUP_B, b);
    write_group(CFG_GROUP_C, c);
    write_group(CFG_GROUP_D, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_group_mode(input int mode);
    case (mode)
      0: set_group_tags(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      1: set_group_tags(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      2: set_group_tags(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: set_group_tags(16'h0001, 16'h0002, 16'h0000, 16'h00FF);
    endcase
  endtask

  function automatic logic [TAG_BITS-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return group_tags[$urandom_range(0, 3)];
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0: return 16'h0000;
        1: return 16'h0001;
        2: return 16'h0002;
        3: return 16'h0003;
        default: return 16'hFFFF;
      endcase
    end
    return TAG_BITS'($urandom);
  endfunction

  function automatic logic [5:0] pick_level();
    if ($urandom_range(0, 99) < 70)
      return 6'((model_fill > 63) ? $urandom_range(0, 63) : $urandom_range(0, model_fill));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic random_request(input int push_pct);
    logic [2:0] req;
    if ($urandom_range(0, 99) < push_pct) begin
      req = REQ_PUSH;
    end else begin
      case ($urandom_range(0, 12))
        0, 1, 2: req = REQ_POP;
        3, 4:    req = REQ_TEST;
        5:       req = REQ_COUNT_ALL;
        6, 7:    req = REQ_COUNT_BELOW;
        8, 9:    req = REQ_REMOVE;
        10, 11:  req = REQ_PEEK;
        default: req = REQ_UNUSED;
      endcase
    end
    send_item(req, pick_tag(), pick_level());
  endtask

  task automatic test_empty_stack();
    send_item(REQ_POP, 16'h0000, 6'd0);
    send_item(REQ_PEEK, 16'h0000, 6'd0);
    send_item(REQ_TEST, 16'h0000, 6'd0);
    send_item(REQ_REMOVE, 16'h0005, 6'd0);
    send_item(REQ_COUNT_BELOW, 16'h0005, 6'd0);
    send_item(REQ_UNUSED, 16'hFFFF, 6'h3F);
  endtask

  task automatic test_group_search();
    // Slot c is left at zero, so a pushed zero tag must not count.
    set_group_tags(16'h0011, 16'hFFFF, 16'h0000, 16'h8000);
    send_item(REQ_PUSH, 16'hFFFF, 6'd0);
    send_item(REQ_PUSH, 16'h0000, 6'd0);
    send_item(REQ_PUSH, 16'h0011, 6'd0);
    send_item(REQ_PUSH, 16'h1234, 6'd0);
    send_item(REQ_PUSH, 16'h0011, 6'd0);
    send_item(REQ_PUSH, 16'h8000, 6'd0);
    send_item(REQ_COUNT_ALL, 16'h0000, 6'd0);
    send_item(REQ_COUNT_BELOW, 16'h0011, 6'd0);
    send_item(REQ_COUNT_BELOW, 16'h7777, 6'd0);
    send_item(REQ_TEST, 16'h0000, 6'd0);
    send_item(REQ_PEEK, 16'h0000, 6'd0);
    send_item(REQ_PEEK, 16'h0000, 6'd5);
    send_item(REQ_PEEK, 16'h0000, 6'h3F);
    send_item(REQ_REMOVE, 16'h0011, 6'd0);
    send_item(REQ_REMOVE, 16'h4321, 6'd0);
  endtask

  task automatic test_pop_to_bottom();
    // The last pop hits the bottom entry, which stays and is reported.
    repeat (5) send_item(REQ_POP, 16'h0000, 6'd0);
  endtask

  task automatic test_fill_to_overflow();
    apply_group_mode(2);
    while (overflow_hits < 3) random_request(85);
    repeat (60) random_request(10);
  endtask

  task automatic test_random_phases();
    int push_pct [8] = '{65, 30, 50, 20, 75, 45, 55, 35};
    for (int p = 0; p < 8; p++) begin
      apply_group_mode(p % 4);
      repeat (170) random_request(push_pct[p]);
    end
  endtask

  task automatic test_back_to_back();
    apply_group_mode(3);
    idle_enable = 1'b0;
    repeat (150) random_request(50);
  endtask

  always @(posedge clk) begin
    stack_result_t exp;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tag_out %h, depth_out %0d", tag_out, depth_out);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (tag_out !== exp.tag) begin
          $error("tag_out mismatch: expected %h, actual %h", exp.tag, tag_out);
          fail_count++;
        end
        if (found !== exp.found) begin
          $error("found mismatch: expected %0d, actual %0d", exp.found, found);
          fail_count++;
        end
        if (group_count !== exp.count) begin
          $error("group_count mismatch: expected %0d, actual %0d", exp.count, group_count);
          fail_count++;
        end
        if (status !== exp.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp.status, status);
          fail_count++;
        end
        if (depth_out !== exp.depth) begin
          $error("depth_out mismatch: expected %0d, actual %0d", exp.depth, depth_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_empty_stack();
    test_group_search();
    test_pop_to_bottom();
    test_fill_to_overflow();
    test_random_phases();
    test_back_to_back();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
